/* src/sha1_stream_hasher_assert.svh */
// Assertion macros shared by the hasher RTL.
`ifndef SHA1_STREAM_HASHER_ASSERT_SVH
`define SHA1_STREAM_HASHER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define SHA1_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SHA1_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/sha1_pkg.sv */
`default_nettype none
package sha1_pkg;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } sha1_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha1_out_t;

  // Classified operation handed from the front end to the core.
  typedef struct packed {
    logic       finish;
    logic [7:0] data_byte;
  } sha1_op_t;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned LAST_IDX = 4;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_VAL [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage
`default_nettype wire

/* src/sha1_stream_hasher.sv */
`default_nettype none
// Absorb item: taken by the core from the input queue; every 64th byte then holds
// the core for setup, 16 word loads, 80 rounds and the final add.
// Finish item: one padded block or two are compressed, then five words are emitted.
// Throughput set by the single 80-round compression unit, one round per cycle.
// Synchronous active-low reset restores the SHA-1 initial chaining value.
// A two-entry queue decouples input acceptance from the core.
module sha1_stream_hasher (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_push,
  output logic                 in_full,
  input  sha1_pkg::sha1_in_t   in_item,
  output logic                 out_empty,
  input  wire logic            out_pop,
  output sha1_pkg::sha1_out_t  out_item
);
  import sha1_pkg::*;

  sha1_op_t op;
  logic     op_valid, op_take;
  logic     last_ok;

  sha1_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_item(in_item), .op_valid(op_valid), .op_take(op_take), .op(op)
  );

  sha1_core u_core (
    .clk(clk), .rst_n(rst_n), .op_valid(op_valid), .op_take(op_take), .op(op),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
  );

  // The last flag marks exactly the final digest word.
  assign last_ok = (out_item.last_word == (out_item.word_index == 3'(LAST_IDX)));

`include "sha1_stream_hasher_assert.svh"

  `SHA1_ASSERT_ALWAYS(a_idx_range, out_empty || out_item.word_index <= 3'(LAST_IDX), "bad index")
  `SHA1_ASSERT_ALWAYS(a_last, out_empty || last_ok, "last mismatch")
  `SHA1_ASSERT_ALWAYS(a_take_idle, !op_take || out_empty, "take while emitting")
  `SHA1_ASSERT_NEXT(a_hold, !out_empty && !out_pop, !out_empty && $stable(out_item), "word not held")

endmodule
`default_nettype wire

/* src/sha1_front.sv */
`default_nettype none
// Front end: classifies input items and queues them for the core.
module sha1_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  sha1_pkg::sha1_in_t     in_item,
  output logic                   op_valid,
  input  wire logic              op_take,
  output sha1_pkg::sha1_op_t     op
);
  import sha1_pkg::*;

  sha1_op_t   q_r [QDEPTH];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push_ok, take_ok;

  assign in_full  = (cnt_r == 2'(QDEPTH));
  assign op_valid = (cnt_r != 2'd0);
  assign op       = q_r[rp_r];
  assign push_ok  = in_push && !in_full;
  assign take_ok  = op_take && op_valid;

  // Pointer and count update.
  always_comb begin
    wp_nxt  = wp_r ^ push_ok;
    rp_nxt  = rp_r ^ take_ok;
    cnt_nxt = cnt_r + 2'(push_ok) - 2'(take_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage; the command is decoded into a finish flag.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r].finish    <= (in_item.command == CMD_FINISH);
      q_r[wp_r].data_byte <= in_item.data_byte;
    end
  end

endmodule
`default_nettype wire

/* src/sha1_core.sv */
`default_nettype none
// Back end: message buffer, 80-round compression unit, padding and digest output.
module sha1_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              op_valid,
  output logic                   op_take,
  input  sha1_pkg::sha1_op_t     op,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output sha1_pkg::sha1_out_t    out_item
);
  import sha1_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PAD   = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_LOAD2 = 7'b0001000,
    S_ROUND = 7'b0010000,
    S_ADD   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t       st_r, st_nxt;
  logic [31:0]  hv_r [5];
  logic [31:0]  tv_r [5];
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [31:0]  w_r [16];
  logic [31:0]  msg_r [16];
  logic [5:0]   fill_r;
  logic [63:0]  total_r;
  logic [6:0]   rnd_r;
  logic [1:0]   pass_r;
  logic         fin_r;
  logic [3:0]   widx_r;
  logic [2:0]   oidx_r;
  logic [5:0]   pos_r;
  logic [63:0]  bits_w;
  logic [31:0]  pad_w;
  logic [31:0]  f_w, k_w, t_w, wn_w;
  logic [1:0]   kind_w;

  assign bits_w = {total_r[60:0], 3'b000};
  assign op_take = (st_r == S_IDLE) && op_valid;
  assign out_empty = (st_r != S_EMIT);
  assign out_item.digest_word = tv_r[oidx_r];
  assign out_item.word_index  = oidx_r;
  assign out_item.last_word   = (oidx_r == 3'(LAST_IDX));

  // Round function and schedule word.
  always_comb begin
    kind_w = (rnd_r < 7'd20) ? 2'd0 : (rnd_r < 7'd40) ? 2'd1 :
             (rnd_r < 7'd60) ? 2'd2 : 2'd3;
    case (kind_w)
      2'd0:    f_w = ((c_r ^ d_r) & b_r) ^ d_r;
      2'd2:    f_w = ((b_r | c_r) & d_r) | (b_r & c_r);
      default: f_w = b_r ^ c_r ^ d_r;
    endcase
    k_w  = K_VAL[kind_w];
    t_w  = {a_r[26:0], a_r[31:27]} + f_w + e_r + k_w + w_r[0];
    wn_w = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    wn_w = {wn_w[30:0], wn_w[31]};
  end

  // Padded block word: message bytes, the 0x80 marker and zeros on the first pass,
  // and the bit length in the last two words of the final block.
  always_comb begin
    pad_w = 32'd0;
    for (int b = 0; b < 4; b++) begin
      if (pass_r == 2'd1 && {widx_r, 2'(b)} < pos_r)
        pad_w[8*(3-b) +: 8] = msg_r[widx_r][8*(3-b) +: 8];
      else if (pass_r == 2'd1 && {widx_r, 2'(b)} == pos_r)
        pad_w[8*(3-b) +: 8] = PAD_BYTE;
    end
    if (widx_r >= 4'd14 && (pos_r < 6'd56 || pass_r == 2'd2))
      pad_w = widx_r[0] ? bits_w[31:0] : bits_w[63:32];
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (op_valid) st_nxt = op.finish ? S_PAD : (fill_r == 6'd63 ? S_LOAD : S_IDLE);
      S_PAD:   st_nxt = S_LOAD;
      S_LOAD:  st_nxt = S_LOAD2;
      S_LOAD2: if (widx_r == 4'd15) st_nxt = S_ROUND;
      S_ROUND: if (rnd_r == 7'd79) st_nxt = S_ADD;
      S_ADD:   st_nxt = !fin_r ? S_IDLE :
                        ((pass_r == 2'd1 && pos_r >= 6'd56) ? S_PAD : S_EMIT);
      S_EMIT:  if (out_pop && oidx_r == 3'(LAST_IDX)) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // Control, counters and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      fill_r  <= 6'd0;
      total_r <= 64'd0;
      oidx_r  <= 3'd0;
      fin_r   <= 1'b0;
      for (int i = 0; i < 5; i++) hv_r[i] <= H_INIT[i];
    end else begin
      st_r <= st_nxt;
      case (st_r)
        S_IDLE: begin
          rnd_r  <= 7'd0;
          widx_r <= 4'd0;
          oidx_r <= 3'd0;
          if (op_valid) begin
            fin_r <= op.finish;
            pos_r <= fill_r;
            pass_r <= 2'd0;
            for (int i = 0; i < 5; i++) tv_r[i] <= hv_r[i];
            if (!op.finish) begin
              fill_r  <= fill_r + 6'd1;
              total_r <= total_r + 64'd1;
            end
          end
        end
        S_PAD: begin
          pass_r <= pass_r + 2'd1;
        end
        S_LOAD: begin
          a_r <= tv_r[0]; b_r <= tv_r[1]; c_r <= tv_r[2];
          d_r <= tv_r[3]; e_r <= tv_r[4];
        end
        S_LOAD2: begin
          widx_r <= widx_r + 4'd1;
        end
        S_ROUND: begin
          e_r <= d_r; d_r <= c_r; c_r <= {b_r[1:0], b_r[31:2]};
          b_r <= a_r; a_r <= t_w;
          rnd_r <= rnd_r + 7'd1;
        end
        S_ADD: begin
          rnd_r <= 7'd0; widx_r <= 4'd0;
          if (fin_r) begin
            tv_r[0] <= tv_r[0] + a_r; tv_r[1] <= tv_r[1] + b_r;
            tv_r[2] <= tv_r[2] + c_r; tv_r[3] <= tv_r[3] + d_r;
            tv_r[4] <= tv_r[4] + e_r;
          end else begin
            hv_r[0] <= hv_r[0] + a_r; hv_r[1] <= hv_r[1] + b_r;
            hv_r[2] <= hv_r[2] + c_r; hv_r[3] <= hv_r[3] + d_r;
            hv_r[4] <= hv_r[4] + e_r;
          end
        end
        S_EMIT: if (out_pop) oidx_r <= oidx_r + 3'd1;
        default: ;
      endcase
    end
  end

  // Message buffer: sixteen big-endian words, one byte lane written per absorb.
  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && op_valid && !op.finish)
      msg_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= op.data_byte;
  end

  // Sixteen-word schedule window, loaded one word per cycle and shifted once per round.
  always_ff @(posedge clk) begin
    if (st_r == S_LOAD2)
      w_r[widx_r] <= fin_r ? pad_w : msg_r[widx_r];
    if (st_r == S_ROUND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wn_w;
    end
  end

endmodule
`default_nettype wire
